/* design/i2cenc_pkg.sv */
// Shared types and constants for the encoder readout slave.
package i2cenc_pkg;

   localparam logic [2:0] MODE_ENC0_EDGE  = 3'd0;
   localparam logic [2:0] MODE_ENC1_EDGE  = 3'd1;
   localparam logic [2:0] MODE_READ_REQ   = 3'd2;
   localparam logic [2:0] MODE_BYTE_WR    = 3'd3;
   localparam logic [2:0] MODE_OWN_WR_ADR = 3'd4;
   localparam logic [2:0] MODE_NACK       = 3'd5;
   localparam logic [2:0] MODE_STOP       = 3'd6;
   localparam logic [2:0] MODE_BUS_ERROR  = 3'd7;

   localparam logic [7:0] REG_ENC0        = 8'hB0;
   localparam logic [7:0] REG_ADC_LAST    = 8'h03;
   localparam logic [2:0] BYTES_PER_VALUE = 3'd4;

   typedef struct packed {
      logic [2:0] mode;
      logic       phase_b;
      logic [7:0] written_byte;
      logic [9:0] adc_sample;
   } req_type;

   typedef struct packed {
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       ack_enable;
      logic       bus_release;
   } rsp_type;

endpackage

/* design/i2cenc_engine.sv */
// Encoder counters, value latch and byte sequencer for one beat.
module i2cenc_engine
   import i2cenc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    advance,
   input  req_type item,
   output rsp_type result
);

   logic [31:0] count_zero_ff, count_zero_in;
   logic [31:0] count_one_ff, count_one_in;
   logic [31:0] latched_value_ff, latched_value_in;
   logic [2:0]  bytes_left_ff, bytes_left_in;

   logic [31:0] serve_value;
   logic [2:0]  serve_left;
   logic [1:0]  byte_idx;

   always_comb begin
      count_zero_in    = count_zero_ff;
      count_one_in     = count_one_ff;
      latched_value_in = latched_value_ff;
      bytes_left_in    = bytes_left_ff;
      result           = '{tx_valid: 1'b0, tx_byte: 8'h00, ack_enable: 1'b1,
                           bus_release: 1'b0};
      serve_value      = latched_value_ff;
      serve_left       = bytes_left_ff;
      if (bytes_left_ff == 3'd0) begin
         serve_value = count_one_ff;
         serve_left  = BYTES_PER_VALUE;
      end
      byte_idx = 2'd0 - serve_left[1:0];
      case (item.mode)
         MODE_ENC0_EDGE: begin
            count_zero_in = item.phase_b ? count_zero_ff + 32'd1 : count_zero_ff - 32'd1;
         end
         MODE_ENC1_EDGE: begin
            count_one_in = item.phase_b ? count_one_ff + 32'd1 : count_one_ff - 32'd1;
         end
         MODE_READ_REQ: begin
            latched_value_in  = serve_value;
            bytes_left_in     = serve_left - 3'd1;
            result.tx_valid   = 1'b1;
            result.tx_byte    = serve_value[{byte_idx, 3'b000} +: 8];
            result.ack_enable = 1'b0;
         end
         MODE_BYTE_WR: begin
            if (item.written_byte <= REG_ADC_LAST) begin
               latched_value_in = {22'd0, item.adc_sample};
            end else if (item.written_byte == REG_ENC0) begin
               latched_value_in = count_zero_ff;
            end
            bytes_left_in = BYTES_PER_VALUE;
         end
         MODE_BUS_ERROR: begin
            result.bus_release = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_zero_ff    <= '0;
         count_one_ff     <= '0;
         latched_value_ff <= '0;
         bytes_left_ff    <= '0;
      end else if (advance) begin
         count_zero_ff    <= count_zero_in;
         count_one_ff     <= count_one_in;
         latched_value_ff <= latched_value_in;
         bytes_left_ff    <= bytes_left_in;
      end
   end

endmodule

/* design/i2c_slave_encoder_sensor_readout_unit.sv */
// Top level of the encoder readout slave: input register, engine, result register.
// Every beat on req_ yields exactly one beat on rsp_, after passing through the input
// register and the result register. The block takes one beat per cycle while rsp_ is
// not stalled: a beat sits in the input register while the engine updates the encoder
// counts, latched value and byte counter, then moves to the result register. Both
// registers advance together whenever the result register is empty or being taken,
// so throughput is then one beat per cycle.
module i2c_slave_encoder_sensor_readout_unit
   import i2cenc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_mode,
   input  logic       req_phase_b,
   input  logic [7:0] req_written_byte,
   input  logic [9:0] req_adc_sample,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_tx_valid,
   output logic [7:0] rsp_tx_byte,
   output logic       rsp_ack_enable,
   output logic       rsp_bus_release
);

   logic    in_valid_ff, in_valid_in;
   req_type in_item_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_item_ff;
   rsp_type engine_result;
   logic    out_open;
   logic    advance;

   assign out_open  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_open;
   assign req_ready = !in_valid_ff || out_open;

   assign in_valid_in  = req_ready ? req_valid : in_valid_ff;
   assign out_valid_in = out_open ? in_valid_ff : out_valid_ff;

   i2cenc_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_item_ff),
      .result  (engine_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_item_ff <= '{mode: req_mode, phase_b: req_phase_b,
                         written_byte: req_written_byte, adc_sample: req_adc_sample};
      end
      if (advance) begin
         out_item_ff <= engine_result;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_tx_valid    = out_item_ff.tx_valid;
   assign rsp_tx_byte     = out_item_ff.tx_byte;
   assign rsp_ack_enable  = out_item_ff.ack_enable;
   assign rsp_bus_release = out_item_ff.bus_release;

endmodule
